// ----- rtl/fifo_free_list_id_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the free list id allocator
// Clocked property wrappers, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FIFO_FREE_LIST_ID_ALLOCATOR_UNIT_MACROS_SVH
`define FIFO_FREE_LIST_ID_ALLOCATOR_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define FFL_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle
`define FFL_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ffl_pkg.sv -----
// ----------------------------------------------------------------------------
// ffl_pkg
// Beat types, action codes and status codes of the free list id allocator.
// ----------------------------------------------------------------------------
package ffl_pkg;

    localparam int ID_W     = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_USED     = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     id;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0]     result_id;
        logic [STATUS_W-1:0] status;
        logic                in_use;
        logic [COUNT_W-1:0]  free_count;
    } t_out_beat;

endpackage

// ----- rtl/ffl_link_ram.sv -----
// ----------------------------------------------------------------------------
// ffl_link_ram
// Link table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffl_link_ram #(
    parameter int AW = 8,
    parameter int DW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ffl_slot_map.sv -----
// ----------------------------------------------------------------------------
// ffl_slot_map
// Maps an id onto a pool slot and flags ids outside the pool.
// ----------------------------------------------------------------------------
module ffl_slot_map #(
    parameter int POOL_SIZE = 256,
    parameter int AW        = 8
) (
    input  logic [ffl_pkg::ID_W-1:0] i_id,
    input  logic [ffl_pkg::ID_W-1:0] i_base,
    output logic                     o_in_range,
    output logic [AW-1:0]            o_slot
);

    import ffl_pkg::*;

    logic [ID_W:0] off;

    // offset without wrap; the borrow bit marks ids below the base
    assign off        = {1'b0, i_id} - {1'b0, i_base};
    assign o_in_range = !off[ID_W] && (off[ID_W-1:0] < ID_W'(POOL_SIZE));
    assign o_slot     = off[AW-1:0];

endmodule

// ----- rtl/fifo_free_list_id_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_free_list_id_allocator_unit
// Id pool kept as a FIFO free list in a link memory with head, tail and count.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that links every slot in
// ascending order; no request is taken until it ends, while id_base writes
// are taken at any time. Allocate, query and failed requests read the link
// entry, then update and write it back. A free that appends to a non-empty
// list goes on to a tail state, because the old tail and the freed slot are
// two writes on the single write port. A reserve of a slot that is not the
// list head walks the list from the head, one link memory read per cycle,
// until it reaches the slot's predecessor. Results wait in an output register
// plus one holding stage, so the next request is taken while a result still
// waits downstream.
// ----------------------------------------------------------------------------
module fifo_free_list_id_allocator_unit #(
    parameter int POOL_SIZE = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ffl_pkg::t_in_beat            i_in,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ffl_pkg::t_out_beat           o_out,
    // id_base write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ffl_pkg::ID_W-1:0]     i_cfg_data
);

    import ffl_pkg::*;

    `include "fifo_free_list_id_allocator_unit_macros.svh"

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int DW = AW + 2;
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

    typedef struct packed {
        logic          used;
        logic          last;
        logic [AW-1:0] nxt;
    } t_link;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_TAIL  = 5'b01000,
        S_WALK  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_walk, n_walk;
    logic [AW-1:0]   r_sv_nxt, n_sv_nxt;
    logic            r_sv_last, n_sv_last;
    logic [ID_W-1:0] r_base;

    logic [ACTION_W-1:0] r_act;
    logic [AW-1:0]       r_slot;
    logic                r_range;

    logic      r_pend_valid, n_pend_valid;
    t_out_beat r_pend, n_pend;
    logic      r_out_valid;
    t_out_beat r_out;

    logic          map_range;
    logic [AW-1:0] map_slot;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_link         mem_wdata, rd;
    logic [DW-1:0] mem_rdata;

    logic      out_free, in_acc, fin;
    t_out_beat res;
    logic [31:0] cnt_ext;

    // ------------------------------------------------------------------
    // submodules
    ffl_slot_map #(
        .POOL_SIZE (POOL_SIZE),
        .AW        (AW)
    ) u_map (
        .i_id       (i_in.id),
        .i_base     (r_base),
        .o_in_range (map_range),
        .o_slot     (map_slot)
    );

    ffl_link_ram #(
        .AW (AW),
        .DW (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd = t_link'(mem_rdata);

    // ------------------------------------------------------------------
    // handshakes
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_pend_valid || out_free));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // sequencer: read, modify, write back
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_walk       = r_walk;
        n_sv_nxt     = r_sv_nxt;
        n_sv_last    = r_sv_last;
        mem_we       = 1'b0;
        mem_waddr    = r_slot;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = r_slot;
        fin          = 1'b0;
        res          = '0;
        res.status   = ST_OK;
        n_pend_valid = r_pend_valid && !out_free;
        n_pend       = r_pend;

        case (r_state)
            S_CLEAR: begin
                mem_we         = 1'b1;
                mem_waddr      = r_clr;
                mem_wdata.used = 1'b0;
                mem_wdata.last = (r_clr == LAST_SLOT);
                mem_wdata.nxt  = (r_clr == LAST_SLOT) ? '0 : r_clr + 1'b1;
                n_clr          = r_clr + 1'b1;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    mem_re    = 1'b1;
                    mem_raddr = (i_in.action == ACT_ALLOC) ? r_head : map_slot;
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                case (r_act)
                    ACT_ALLOC: begin
                        fin = 1'b1;
                        if (r_count == '0) begin
                            res.status = ST_EMPTY;
                        end else begin
                            mem_we         = 1'b1;
                            mem_waddr      = r_head;
                            mem_wdata      = rd;
                            mem_wdata.used = 1'b1;
                            if (r_count > CW'(1)) begin
                                n_head = rd.nxt;
                            end
                            n_count       = r_count - 1'b1;
                            res.result_id = ID_W'(r_head) + r_base;
                        end
                    end

                    ACT_FREE: begin
                        if (!r_range) begin
                            fin        = 1'b1;
                            res.status = ST_RANGE;
                        end else if (!rd.used) begin
                            fin        = 1'b1;
                            res.status = ST_NOT_USED;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_tail  = r_slot;
                            mem_we  = 1'b1;
                            if (r_count != '0) begin
                                // link the old tail to the freed slot first
                                mem_waddr      = r_tail;
                                mem_wdata.nxt  = r_slot;
                                n_state        = S_TAIL;
                            end else begin
                                mem_waddr      = r_slot;
                                mem_wdata.last = 1'b1;
                                n_head         = r_slot;
                                fin            = 1'b1;
                            end
                        end
                    end

                    ACT_RESERVE: begin
                        if (!r_range) begin
                            fin        = 1'b1;
                            res.status = ST_RANGE;
                        end else if (rd.used) begin
                            fin        = 1'b1;
                            res.status = ST_USED;
                        end else begin
                            n_count        = r_count - 1'b1;
                            mem_we         = 1'b1;
                            mem_waddr      = r_slot;
                            mem_wdata.used = 1'b1;
                            if ((r_count > CW'(1)) && (r_head != r_slot)) begin
                                // find the predecessor by walking from the head
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_walk    = r_head;
                                n_sv_nxt  = rd.nxt;
                                n_sv_last = rd.last;
                                n_state   = S_WALK;
                            end else begin
                                if (r_count > CW'(1)) begin
                                    n_head = rd.nxt;
                                end
                                fin = 1'b1;
                            end
                        end
                    end

                    default: begin
                        // query
                        fin        = 1'b1;
                        res.in_use = r_range && rd.used;
                    end
                endcase
            end

            S_TAIL: begin
                mem_we         = 1'b1;
                mem_waddr      = r_slot;
                mem_wdata.last = 1'b1;
                fin            = 1'b1;
                n_state        = S_IDLE;
            end

            S_WALK: begin
                if (rd.nxt == r_slot) begin
                    // predecessor takes over the reserved slot's link
                    mem_we         = 1'b1;
                    mem_waddr      = r_walk;
                    mem_wdata.last = r_sv_last;
                    mem_wdata.nxt  = r_sv_nxt;
                    if (r_tail == r_slot) begin
                        n_tail = r_walk;
                    end
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = rd.nxt;
                    n_walk    = rd.nxt;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // finished result goes to the holding stage
        cnt_ext        = 32'(n_count);
        res.free_count = cnt_ext[COUNT_W-1:0];
        if (fin) begin
            n_pend_valid = 1'b1;
            n_pend       = res;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_head       <= '0;
            r_tail       <= LAST_SLOT;
            r_count      <= CW'(POOL_SIZE);
            r_base       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (out_free) begin
                r_out_valid <= r_pend_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    always_ff @(posedge i_clk) begin
        r_walk    <= n_walk;
        r_sv_nxt  <= n_sv_nxt;
        r_sv_last <= n_sv_last;
        r_pend    <= n_pend;
        if (in_acc) begin
            r_act   <= i_in.action;
            r_slot  <= map_slot;
            r_range <= map_range;
        end
        if (out_free) begin
            r_out <= r_pend;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    `FFL_CHECK(a_count_bound, r_count <= CW'(POOL_SIZE), "free count above pool size")
    `FFL_CHECK(a_pend_empty_exec, !((r_state == S_EXEC) && r_pend_valid), "result stage busy")
    `FFL_CHECK(a_walk_not_slot, !((r_state == S_WALK) && (r_walk == r_slot)), "walk hit slot")
    `FFL_CHECK_NEXT(a_count_hold, r_state != S_EXEC, $stable(r_count), "count moved outside exec")

endmodule
